/* rtl/psbf_pkg.sv */
// ----------------------------------------------------------------------------
// psbf_pkg : shared types and constants of the point self box filter
// Field widths, configuration register indexes and the sequencer states.
// ----------------------------------------------------------------------------
package psbf_pkg;

    localparam int unsigned COORD_W   = 24;
    localparam int unsigned SIDE_W    = 48;
    localparam int unsigned ROW_W     = 48;
    localparam int unsigned COEF_W    = 16;
    localparam int unsigned MARGIN_W  = 16;
    localparam int unsigned BCOUNT_W  = 4;
    localparam int unsigned BIDX_W    = 6;
    localparam int unsigned KEPT_W    = 20;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned PROD_W    = COEF_W + COORD_W;
    localparam int unsigned ACC_W     = 44;
    localparam int unsigned FRAC_BITS = 14;
    localparam int unsigned CMP_W     = 32;
    localparam int unsigned BOUNDS_PER_BOX = 6;
    localparam int unsigned IN_DATA_W  = 152;
    localparam int unsigned OUT_DATA_W = 144;

    // Rounding offset: one half in Q2.14.
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(8192);

    localparam logic [KEPT_W-1:0] KEPT_MAX = '1;

    localparam logic [ROW_W-1:0] ROW0_RESET = 48'h4000_0000_0000;
    localparam logic [ROW_W-1:0] ROW1_RESET = 48'h0000_4000_0000;
    localparam logic [ROW_W-1:0] ROW2_RESET = 48'h0000_0000_4000;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 16'd30;

    // Reciprocal of six for bound indexes below 64: q = (idx * 43) >> 8.
    localparam logic [11:0] DIV6_MUL = 12'd43;
    localparam int unsigned DIV6_SHIFT = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROT0    = 3'd0,
        CFG_ROT1    = 3'd1,
        CFG_ROT2    = 3'd2,
        CFG_SHIFT_X = 3'd3,
        CFG_SHIFT_Y = 3'd4,
        CFG_SHIFT_Z = 3'd5,
        CFG_MARGIN  = 3'd6,
        CFG_BCOUNT  = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_XFORM,
        S_BOX,
        S_DONE
    } t_state;

    localparam logic FUNC_POINT = 1'b0;
    localparam logic FUNC_BOUND = 1'b1;

endpackage

/* rtl/psbf_ram.sv */
// ----------------------------------------------------------------------------
// psbf_ram : generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module psbf_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 8
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/point_self_box_filter_unit.sv */
// ----------------------------------------------------------------------------
// point_self_box_filter_unit : crop box self filter for lidar points
// Transforms each point with a configured rotation and translation, tests it
// against up to MAX_BOXES stored boxes widened by a margin, and marks it kept
// or dropped, carrying the original coordinates and a per-frame kept count.
// ----------------------------------------------------------------------------
//
// Channel      Direction  Beat contents
// -----------  ---------  ---------------------------------------------------
// s_axis       in         a point (tuser = 0) or one box bound write (tuser = 1)
// m_axis       out        one result per point, none per bound write
// i_cfg_*      in         register writes, one per cycle, no read-back
//
// A bound write is taken in the idle state and leaves the block idle. A point
// occupies the block from the beat that brings it to the next beat taken:
// three multiply steps on three parallel 16x24 multipliers, one accumulate,
// one round-and-translate step, a loop over the active boxes (box_count,
// capped at MAX_BOXES), reading one box per cycle as a row from the six bound
// memories, comparing each in the cycle after its read and ending in a closing
// step, then the done state that loads the output register once it is free and
// the idle state that takes the next beat. With no active box the loop has only
// its closing step. The result sits in an output register; the next beat is
// taken while it waits, and only a point that finishes while the previous
// result is still held waits for it.
// Reset is synchronous and active low and clears the control state, the
// configuration and the kept count; the bound memories are not cleared and
// must be written before their boxes are used.
// ----------------------------------------------------------------------------
module point_self_box_filter_unit #(
    parameter int unsigned MAX_BOXES = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,

    // Configuration write port.
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_index,
    input  logic [47:0]   i_cfg_wdata,

    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // point_x[23:0], point_y[47:24], point_z[71:48], side_data[119:72],
    // bound_index[125:120], bound_value[149:126], zero pad[151:150]
    input  logic [151:0]  s_axis_tdata,
    // func[0]
    input  logic          s_axis_tuser,
    // frame_end
    input  logic          s_axis_tlast,

    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // out_x[23:0], out_y[47:24], out_z[71:48], out_side_data[119:72],
    // kept_total[139:120], zero pad[143:140]
    output logic [143:0]  m_axis_tdata,
    // keep[0]
    output logic          m_axis_tuser,
    // out_frame_end
    output logic          m_axis_tlast
);

    localparam int unsigned BW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int unsigned CW = $clog2(MAX_BOXES + 1);
    localparam int unsigned NUM_BOUNDS = psbf_pkg::BOUNDS_PER_BOX * MAX_BOXES;

    // ------------------------------------------------------------------
    // Input field unpacking
    // ------------------------------------------------------------------
    logic signed [psbf_pkg::COORD_W-1:0] in_x, in_y, in_z, in_bval;
    logic [psbf_pkg::SIDE_W-1:0]         in_side;
    logic [psbf_pkg::BIDX_W-1:0]         in_bidx;

    assign in_x    = s_axis_tdata[23:0];
    assign in_y    = s_axis_tdata[47:24];
    assign in_z    = s_axis_tdata[71:48];
    assign in_side = s_axis_tdata[119:72];
    assign in_bidx = s_axis_tdata[125:120];
    assign in_bval = s_axis_tdata[149:126];

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [psbf_pkg::ROW_W-1:0]          r_row [3];
    logic signed [psbf_pkg::COORD_W-1:0] r_shift [3];
    logic [psbf_pkg::MARGIN_W-1:0]       r_margin;
    logic [psbf_pkg::BCOUNT_W-1:0]       r_box_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0]    <= psbf_pkg::ROW0_RESET;
            r_row[1]    <= psbf_pkg::ROW1_RESET;
            r_row[2]    <= psbf_pkg::ROW2_RESET;
            r_shift[0]  <= '0;
            r_shift[1]  <= '0;
            r_shift[2]  <= '0;
            r_margin    <= psbf_pkg::MARGIN_RESET;
            r_box_count <= '0;
        end else if (i_cfg_we) begin
            unique case (psbf_pkg::t_cfg_idx'(i_cfg_index))
                psbf_pkg::CFG_ROT0:    r_row[0]    <= i_cfg_wdata;
                psbf_pkg::CFG_ROT1:    r_row[1]    <= i_cfg_wdata;
                psbf_pkg::CFG_ROT2:    r_row[2]    <= i_cfg_wdata;
                psbf_pkg::CFG_SHIFT_X: r_shift[0]  <= i_cfg_wdata[23:0];
                psbf_pkg::CFG_SHIFT_Y: r_shift[1]  <= i_cfg_wdata[23:0];
                psbf_pkg::CFG_SHIFT_Z: r_shift[2]  <= i_cfg_wdata[23:0];
                psbf_pkg::CFG_MARGIN:  r_margin    <= i_cfg_wdata[15:0];
                psbf_pkg::CFG_BCOUNT:  r_box_count <= i_cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // Active box count, capped at MAX_BOXES.
    logic [15:0]   bcount_ext;
    logic [15:0]   n_boxes_ext;
    logic [CW-1:0] n_boxes;

    assign bcount_ext  = 16'(r_box_count);
    assign n_boxes_ext = (bcount_ext > 16'(MAX_BOXES)) ? 16'(MAX_BOXES) : bcount_ext;
    assign n_boxes     = n_boxes_ext[CW-1:0];

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    psbf_pkg::t_state r_state, n_state;
    logic             in_fire;
    logic             out_free;
    logic             ld_out;
    logic [1:0]       r_step;
    logic [CW-1:0]    r_box;
    logic             r_pend;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_axis_tvalid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psbf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        ld_out        = 1'b0;
        unique case (r_state)
            psbf_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid && (s_axis_tuser == psbf_pkg::FUNC_POINT)) begin
                    n_state = psbf_pkg::S_MUL;
                end
            end
            psbf_pkg::S_MUL: begin
                if (r_step == 2'd2) begin
                    n_state = psbf_pkg::S_ACC;
                end
            end
            psbf_pkg::S_ACC:   n_state = psbf_pkg::S_XFORM;
            psbf_pkg::S_XFORM: n_state = psbf_pkg::S_BOX;
            psbf_pkg::S_BOX: begin
                if ((r_box >= n_boxes) && !r_pend) begin
                    n_state = psbf_pkg::S_DONE;
                end
            end
            psbf_pkg::S_DONE: begin
                if (out_free) begin
                    ld_out  = 1'b1;
                    n_state = psbf_pkg::S_IDLE;
                end
            end
            default: n_state = psbf_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Bound write decode: bound_index splits into box and bound kind.
    // ------------------------------------------------------------------
    logic [11:0]   div_prod;
    logic [3:0]    wr_box;
    logic [5:0]    wr_kind_full;
    logic [2:0]    wr_kind;
    logic [15:0]   wr_box_ext;
    logic [BW-1:0] wr_addr;
    logic          wr_ok;

    assign div_prod     = 12'(in_bidx) * psbf_pkg::DIV6_MUL;
    assign wr_box       = div_prod[11:psbf_pkg::DIV6_SHIFT];
    assign wr_kind_full = in_bidx - 6'(6'(wr_box) * 6'd6);
    assign wr_kind      = wr_kind_full[2:0];
    assign wr_box_ext   = 16'(wr_box);
    assign wr_addr      = wr_box_ext[BW-1:0];
    assign wr_ok        = in_fire && (s_axis_tuser == psbf_pkg::FUNC_BOUND) &&
                          (16'(in_bidx) < 16'(NUM_BOUNDS));

    // Six bound memories, one per bound kind, addressed by box number, so
    // that a whole box is read at once.
    logic [psbf_pkg::COORD_W-1:0] rd_bound [psbf_pkg::BOUNDS_PER_BOX];
    logic [BW-1:0]                rd_addr;

    assign rd_addr = r_box[BW-1:0];

    for (genvar g = 0; g < psbf_pkg::BOUNDS_PER_BOX; g++) begin : g_bound_mem
        psbf_ram #(
            .WIDTH (psbf_pkg::COORD_W),
            .DEPTH (MAX_BOXES)
        ) u_bound_ram (
            .i_clk   (i_clk),
            .i_we    (wr_ok && (wr_kind == 3'(g))),
            .i_waddr (wr_addr),
            .i_wdata (in_bval),
            .i_raddr (rd_addr),
            .o_rdata (rd_bound[g])
        );
    end

    // ------------------------------------------------------------------
    // Point capture and transform
    // ------------------------------------------------------------------
    logic signed [psbf_pkg::COORD_W-1:0] r_px, r_py, r_pz;
    logic [psbf_pkg::SIDE_W-1:0]         r_pside;
    logic                                r_plast;
    logic signed [psbf_pkg::PROD_W-1:0]  r_prod [3];
    logic signed [psbf_pkg::ACC_W-1:0]   r_acc [3];
    logic signed [psbf_pkg::CMP_W-1:0]   r_t [3];

    logic signed [psbf_pkg::COORD_W-1:0] mul_coord;
    logic signed [psbf_pkg::COEF_W-1:0]  mul_coef [3];
    logic signed [psbf_pkg::PROD_W-1:0]  mul_res [3];
    logic signed [psbf_pkg::ACC_W-1:0]   acc_shr [3];

    // Step k multiplies every row's k-th coefficient with coordinate k.
    always_comb begin
        unique case (r_step)
            2'd0:    mul_coord = r_px;
            2'd1:    mul_coord = r_py;
            default: mul_coord = r_pz;
        endcase
        for (int i = 0; i < 3; i++) begin
            unique case (r_step)
                2'd0:    mul_coef[i] = r_row[i][47:32];
                2'd1:    mul_coef[i] = r_row[i][31:16];
                default: mul_coef[i] = r_row[i][15:0];
            endcase
            mul_res[i] = psbf_pkg::PROD_W'(mul_coef[i] * mul_coord);
            acc_shr[i] = r_acc[i] >>> psbf_pkg::FRAC_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && (s_axis_tuser == psbf_pkg::FUNC_POINT)) begin
            r_px    <= in_x;
            r_py    <= in_y;
            r_pz    <= in_z;
            r_pside <= in_side;
            r_plast <= s_axis_tlast;
        end
        for (int i = 0; i < 3; i++) begin
            if (r_state == psbf_pkg::S_MUL) begin
                r_prod[i] <= mul_res[i];
                r_acc[i]  <= (r_step == 2'd0) ? '0 :
                             r_acc[i] + psbf_pkg::ACC_W'(r_prod[i]);
            end else if (r_state == psbf_pkg::S_ACC) begin
                // Last product, with the half for round-half-up.
                r_acc[i] <= r_acc[i] + psbf_pkg::ACC_W'(r_prod[i]) + psbf_pkg::ROUND_HALF;
            end
            if (r_state == psbf_pkg::S_XFORM) begin
                r_t[i] <= psbf_pkg::CMP_W'(acc_shr[i]) + psbf_pkg::CMP_W'(r_shift[i]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Box loop: read box r_box, compare the box read in the previous cycle.
    // ------------------------------------------------------------------
    logic signed [psbf_pkg::CMP_W-1:0] margin_s;
    logic signed [psbf_pkg::CMP_W-1:0] lo [3];
    logic signed [psbf_pkg::CMP_W-1:0] hi [3];
    logic                              axis_in [3];
    logic                              box_hit;
    logic                              r_inside;

    assign margin_s = psbf_pkg::CMP_W'(r_margin);

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            lo[a] = psbf_pkg::CMP_W'($signed(rd_bound[2*a]))     - margin_s;
            hi[a] = psbf_pkg::CMP_W'($signed(rd_bound[2*a + 1])) + margin_s;
            axis_in[a] = (lo[a] <= r_t[a]) && (r_t[a] <= hi[a]);
        end
        box_hit = axis_in[0] && axis_in[1] && axis_in[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_box  <= '0;
            r_pend <= 1'b0;
        end else begin
            if (r_state == psbf_pkg::S_MUL) begin
                r_step <= r_step + 2'd1;
            end else begin
                r_step <= '0;
            end
            if (r_state == psbf_pkg::S_BOX) begin
                if (r_box < n_boxes) begin
                    r_box  <= r_box + CW'(1);
                    r_pend <= 1'b1;
                end else begin
                    r_pend <= 1'b0;
                end
            end else begin
                r_box  <= '0;
                r_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == psbf_pkg::S_XFORM) begin
            r_inside <= 1'b0;
        end else if ((r_state == psbf_pkg::S_BOX) && r_pend && box_hit) begin
            r_inside <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Kept count and output register
    // ------------------------------------------------------------------
    logic [psbf_pkg::KEPT_W-1:0] r_kept;
    logic [psbf_pkg::KEPT_W-1:0] kept_next;
    logic                        r_out_valid;
    logic                        r_out_keep;
    logic                        r_out_last;
    logic [psbf_pkg::COORD_W-1:0] r_out_x, r_out_y, r_out_z;
    logic [psbf_pkg::SIDE_W-1:0]  r_out_side;
    logic [psbf_pkg::KEPT_W-1:0]  r_out_kept;

    assign kept_next = (!r_inside && (r_kept != psbf_pkg::KEPT_MAX)) ?
                       r_kept + psbf_pkg::KEPT_W'(1) : r_kept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kept      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (ld_out) begin
                r_kept      <= r_plast ? '0 : kept_next;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_out) begin
            r_out_keep <= !r_inside;
            r_out_last <= r_plast;
            r_out_x    <= r_px;
            r_out_y    <= r_py;
            r_out_z    <= r_pz;
            r_out_side <= r_pside;
            r_out_kept <= kept_next;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_keep;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {4'b0, r_out_kept, r_out_side, r_out_z, r_out_y, r_out_x};

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb : self-checking bench for point_self_box_filter_unit
// Streams points and box bound writes into the filter, works out the keep flag
// and the running kept count of every point with its own transform and box
// test, and checks each result beat field by field.
// ----------------------------------------------------------------------------
module tb;
    import psbf_pkg::*;

    localparam int unsigned MAX_BOXES     = 8;
    localparam int unsigned BOUND_SLOTS   = BOUNDS_PER_BOX * MAX_BOXES;
    localparam int unsigned RESET_CYCLES  = 7;
    localparam int unsigned PHASE_COUNT   = 6;
    localparam int unsigned PHASE_BEATS   = 320;
    // A point runs through the box loop and a result may sit in the output
    // register behind it; this margin is meant to cover any work in flight.
    localparam int unsigned SETTLE_CYCLES = 32;
    localparam int unsigned CYCLE_LIMIT   = 600000;

    localparam logic signed [COORD_W-1:0] COORD_TOP    = 24'h7FFFFF;
    localparam logic signed [COORD_W-1:0] COORD_BOTTOM = 24'h800000;

    // One input beat: a point to filter or a bound write, chosen by func.
    typedef struct {
        logic                      func;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
        logic [SIDE_W-1:0]         side;
        logic                      fe;
        logic [BIDX_W-1:0]         bidx;
        logic signed [COORD_W-1:0] bval;
    } t_sensor_beat;

    // One result beat as the filter should give it.
    typedef struct {
        logic               keep;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [SIDE_W-1:0]  side;
        logic               fe;
        logic [KEPT_W-1:0]  kept;
    } t_due_result;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_cfg_we = 1'b0;
    logic [2:0]     i_cfg_index = '0;
    logic [47:0]    i_cfg_wdata = '0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [151:0]   s_axis_tdata = '0;
    logic           s_axis_tuser = 1'b0;
    logic           s_axis_tlast = 1'b0;
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    logic [143:0]   m_axis_tdata;
    logic           m_axis_tuser;
    logic           m_axis_tlast;

    // Shadow of the filter: configuration, stored bounds and the kept count.
    logic [ROW_W-1:0]          rot_row [3];
    longint                    shift_mm [3];
    longint                    margin_mm;
    int unsigned               box_count_reg;
    logic signed [COORD_W-1:0] bound_mm [BOUND_SLOTS];
    logic [KEPT_W-1:0]         kept_so_far;

    t_sensor_beat beats_to_send [$];
    t_due_result  results_due [$];
    t_sensor_beat beat_on_bus;
    t_due_result  oldest_due;

    int unsigned send_gap_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned fault_count    = 0;
    int unsigned results_checked = 0;
    int unsigned drops_seen     = 0;
    int unsigned bounds_sent    = 0;
    int unsigned cycle_count    = 0;

    point_self_box_filter_unit #(
        .MAX_BOXES     (MAX_BOXES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Transform and box test
    // ------------------------------------------------------------------------

    // One axis of the moved point: the dot product of a Q2.14 row with the
    // point, rounded to the nearest millimetre with halves going upwards, then
    // the translation. Everything is kept at full precision in 64 bits.
    function automatic longint xform_axis(logic [ROW_W-1:0] row, longint x, longint y,
                                          longint z, longint shift);
        longint cx;
        longint cy;
        longint cz;
        longint acc;
        cx = $signed(row[47:32]);
        cy = $signed(row[31:16]);
        cz = $signed(row[15:0]);
        acc = cx * x + cy * y + cz * z;
        return ((acc + 64'sd8192) >>> FRAC_BITS) + shift;
    endfunction

    // Works out the result of a point and moves the kept count along. A point
    // is dropped when it falls inside any active box on all three axes, the
    // box having been widened by the margin on every side.
    function automatic t_due_result predict_point(t_sensor_beat b);
        t_due_result r;
        longint      moved [3];
        longint      lo;
        longint      hi;
        int unsigned active;
        logic        boxed;
        logic        hit;
        for (int a = 0; a < 3; a++)
            moved[a] = xform_axis(rot_row[a], b.px, b.py, b.pz, shift_mm[a]);
        active = (box_count_reg > MAX_BOXES) ? MAX_BOXES : box_count_reg;
        boxed = 1'b0;
        for (int unsigned k = 0; k < active; k++) begin
            hit = 1'b1;
            for (int a = 0; a < 3; a++) begin
                lo = longint'(bound_mm[k * BOUNDS_PER_BOX + 2 * a]) - margin_mm;
                hi = longint'(bound_mm[k * BOUNDS_PER_BOX + 2 * a + 1]) + margin_mm;
                if (moved[a] < lo || moved[a] > hi)
                    hit = 1'b0;
            end
            if (hit)
                boxed = 1'b1;
        end
        if (!boxed && kept_so_far != KEPT_MAX)
            kept_so_far = kept_so_far + 1'b1;
        r.keep = !boxed;
        r.x    = b.px;
        r.y    = b.py;
        r.z    = b.pz;
        r.side = b.side;
        r.fe   = b.fe;
        r.kept = kept_so_far;
        if (b.fe)
            kept_so_far = '0;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: presents queued beats, with random gaps between them. The
    // outcome of every accepted beat is worked out at the edge that takes it.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic busy;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            busy = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                busy = 1'b0;
                if (beat_on_bus.func == FUNC_BOUND) begin
                    // Writes beyond the last box slot are ignored by the block.
                    if (beat_on_bus.bidx < BOUND_SLOTS)
                        bound_mm[beat_on_bus.bidx] = beat_on_bus.bval;
                end else begin
                    results_due = {results_due, predict_point(beat_on_bus)};
                end
            end
            if (!busy && beats_to_send.size() != 0
                    && $urandom_range(0, 99) >= send_gap_pct) begin
                beat_on_bus = beats_to_send.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {2'b00, beat_on_bus.bval, beat_on_bus.bidx,
                                  beat_on_bus.side, beat_on_bus.pz, beat_on_bus.py,
                                  beat_on_bus.px};
                s_axis_tuser  <= beat_on_bus.func;
                s_axis_tlast  <= beat_on_bus.fe;
            end else if (!busy) begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: takes result beats with random stalls and checks each against
    // the oldest outstanding expectation.
    // ------------------------------------------------------------------------
    task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            fault_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, got tdata %0h",
                             $time, m_axis_tdata);
                    fault_count++;
                end else begin
                    oldest_due = results_due.pop_front();
                    check_field("keep", oldest_due.keep, m_axis_tuser);
                    check_field("out_x", oldest_due.x, m_axis_tdata[23:0]);
                    check_field("out_y", oldest_due.y, m_axis_tdata[47:24]);
                    check_field("out_z", oldest_due.z, m_axis_tdata[71:48]);
                    check_field("out_side_data", oldest_due.side, m_axis_tdata[119:72]);
                    check_field("out_frame_end", oldest_due.fe, m_axis_tlast);
                    check_field("kept_total", oldest_due.kept, m_axis_tdata[139:120]);
                    results_checked++;
                    if (!oldest_due.keep)
                        drops_seen++;
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // A hung handshake must not leave the run waiting for ever.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("** point_self_box_filter_unit: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // The fields that a beat's func does not use are filled at random too,
    // since the block has to ignore them.
    function automatic t_sensor_beat random_beat();
        t_sensor_beat b;
        b.func = FUNC_POINT;
        b.px   = COORD_W'($urandom);
        b.py   = COORD_W'($urandom);
        b.pz   = COORD_W'($urandom);
        b.side = SIDE_W'({$urandom, $urandom});
        b.fe   = ($urandom_range(0, 15) == 0);
        b.bidx = BIDX_W'($urandom);
        b.bval = COORD_W'($urandom);
        return b;
    endfunction

    task automatic add_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                             logic signed [COORD_W-1:0] z);
        t_sensor_beat b;
        b = random_beat();
        b.px = x;
        b.py = y;
        b.pz = z;
        beats_to_send = {beats_to_send, b};
    endtask

    task automatic add_bound(logic [BIDX_W-1:0] idx, logic signed [COORD_W-1:0] val);
        t_sensor_beat b;
        b = random_beat();
        b.func = FUNC_BOUND;
        b.bidx = idx;
        b.bval = val;
        beats_to_send = {beats_to_send, b};
        bounds_sent++;
    endtask

    // Mostly modest coordinates, with the ends of the range and wide values
    // mixed in.
    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       return COORD_TOP;
            1:       return COORD_BOTTOM;
            2, 3:    return COORD_W'($urandom);
            default: return COORD_W'(longint'($urandom_range(0, 6000)) - 64'sd3000);
        endcase
    endfunction

    // Register writes go in one at a time, with the write enable dropped between
    // them, and update the shadow at once; they are only issued while the block is idle.
    task automatic write_reg(t_cfg_idx idx, logic [47:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_ROT0:    rot_row[0] = val;
            CFG_ROT1:    rot_row[1] = val;
            CFG_ROT2:    rot_row[2] = val;
            CFG_SHIFT_X: shift_mm[0] = $signed(val[COORD_W-1:0]);
            CFG_SHIFT_Y: shift_mm[1] = $signed(val[COORD_W-1:0]);
            CFG_SHIFT_Z: shift_mm[2] = $signed(val[COORD_W-1:0]);
            CFG_MARGIN:  margin_mm = val[MARGIN_W-1:0];
            CFG_BCOUNT:  box_count_reg = val[BCOUNT_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Holds the sender back until every beat has gone in and every result
    // has come out, then lets a bound write still in flight settle.
    task automatic wait_drained();
        while (beats_to_send.size() != 0 || s_axis_tvalid || results_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One well-formed piece of traffic. Most often a box is built around
    // where a chosen point lands after the transform, and points scattered
    // around that one then probe its faces, inside and out. Otherwise a lone
    // bound write with any index, or a lone point anywhere.
    task automatic add_sequence(inout int unsigned added);
        int unsigned pick;
        int unsigned slot;
        int unsigned active;
        int unsigned probes;
        longint      moved;
        longint      lo;
        longint      hi;
        longint      span;
        logic signed [COORD_W-1:0] base [3];
        logic signed [COORD_W-1:0] spot [3];
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            active = (box_count_reg > MAX_BOXES) ? MAX_BOXES : box_count_reg;
            slot = (active == 0) ? $urandom_range(0, MAX_BOXES - 1)
                                 : $urandom_range(0, active - 1);
            for (int a = 0; a < 3; a++)
                base[a] = rand_coord();
            for (int a = 0; a < 3; a++) begin
                moved = xform_axis(rot_row[a], base[0], base[1], base[2], shift_mm[a]);
                if ($urandom_range(0, 7) == 0) begin
                    // Reversed even after widening, so this box can drop nothing.
                    lo = moved + 2 * margin_mm + longint'($urandom_range(1, 50));
                    hi = moved;
                end else begin
                    lo = moved - longint'($urandom_range(0, 40));
                    hi = moved + longint'($urandom_range(0, 40));
                end
                add_bound(BIDX_W'(slot * BOUNDS_PER_BOX + 2 * a), COORD_W'(lo));
                add_bound(BIDX_W'(slot * BOUNDS_PER_BOX + 2 * a + 1), COORD_W'(hi));
            end
            added += BOUNDS_PER_BOX;
            probes = $urandom_range(2, 6);
            span = margin_mm + 60;
            for (int unsigned k = 0; k < probes; k++) begin
                for (int a = 0; a < 3; a++)
                    spot[a] = (k == 0 || $urandom_range(0, 3) == 0) ? base[a]
                            : COORD_W'(longint'(base[a])
                                       + longint'($urandom_range(0, 2 * span)) - span);
                add_point(spot[0], spot[1], spot[2]);
            end
            added += probes;
        end else if (pick < 65) begin
            add_bound(BIDX_W'($urandom_range(0, 63)), COORD_W'($urandom));
            added++;
        end else begin
            add_point(rand_coord(), rand_coord(), rand_coord());
            added++;
        end
    endtask

    function automatic logic [ROW_W-1:0] pack_row(logic [COEF_W-1:0] cx,
                                                  logic [COEF_W-1:0] cy,
                                                  logic [COEF_W-1:0] cz);
        return {cx, cy, cz};
    endfunction

    function automatic logic [47:0] rand_shift();
        return {24'd0, COORD_W'($urandom)};
    endfunction

    // Each setting writes every register. Across the settings the margin runs
    // from 0 to its top, the box count from 0 to above the number of slots,
    // and the rotations go from plain and signed axis swaps with half-scale
    // coefficients (where exact halves must round upwards) to arbitrary ones
    // including the most negative and most positive coefficient.
    task automatic setup_phase(int unsigned ph);
        case (ph)
            0: begin
                write_reg(CFG_ROT0, ROW0_RESET);
                write_reg(CFG_ROT1, ROW1_RESET);
                write_reg(CFG_ROT2, ROW2_RESET);
                write_reg(CFG_SHIFT_X, 48'd0);
                write_reg(CFG_SHIFT_Y, 48'd0);
                write_reg(CFG_SHIFT_Z, 48'd0);
                write_reg(CFG_MARGIN, MARGIN_RESET);
                write_reg(CFG_BCOUNT, 48'd8);
            end
            1: begin
                write_reg(CFG_ROT0, pack_row(16'h0000, 16'h2000, 16'h0000));
                write_reg(CFG_ROT1, pack_row(16'h0000, 16'h0000, 16'hC000));
                write_reg(CFG_ROT2, pack_row(16'hE000, 16'h0000, 16'h0000));
                write_reg(CFG_SHIFT_X, {24'd0, COORD_W'(longint'($urandom_range(0, 10000)) - 5000)});
                write_reg(CFG_SHIFT_Y, rand_shift());
                write_reg(CFG_SHIFT_Z, {24'd0, COORD_W'(longint'($urandom_range(0, 10000)) - 5000)});
                write_reg(CFG_MARGIN, 48'($urandom_range(0, 200)));
                write_reg(CFG_BCOUNT, 48'd15);
            end
            2: begin
                write_reg(CFG_ROT0, pack_row(16'h8000, 16'h7FFF, COEF_W'($urandom)));
                write_reg(CFG_ROT1, ROW_W'({$urandom, $urandom}));
                write_reg(CFG_ROT2, ROW_W'({$urandom, $urandom}));
                write_reg(CFG_SHIFT_X, {24'd0, COORD_TOP});
                write_reg(CFG_SHIFT_Y, {24'd0, COORD_BOTTOM});
                write_reg(CFG_SHIFT_Z, rand_shift());
                write_reg(CFG_MARGIN, 48'hFFFF);
                write_reg(CFG_BCOUNT, 48'($urandom_range(1, MAX_BOXES)));
            end
            3: begin
                write_reg(CFG_ROT0, pack_row(16'hC000, 16'h0000, 16'h0000));
                write_reg(CFG_ROT1, ROW1_RESET);
                write_reg(CFG_ROT2, ROW2_RESET);
                write_reg(CFG_SHIFT_X, rand_shift());
                write_reg(CFG_SHIFT_Y, rand_shift());
                write_reg(CFG_SHIFT_Z, rand_shift());
                write_reg(CFG_MARGIN, 48'd0);
                write_reg(CFG_BCOUNT, 48'd3);
            end
            4: begin
                write_reg(CFG_ROT0, ROW_W'({$urandom, $urandom}));
                write_reg(CFG_ROT1, ROW_W'({$urandom, $urandom}));
                write_reg(CFG_ROT2, ROW_W'({$urandom, $urandom}));
                write_reg(CFG_SHIFT_X, rand_shift());
                write_reg(CFG_SHIFT_Y, rand_shift());
                write_reg(CFG_SHIFT_Z, rand_shift());
                write_reg(CFG_MARGIN, 48'($urandom_range(0, 65535)));
                write_reg(CFG_BCOUNT, 48'd0);
            end
            default: begin
                write_reg(CFG_ROT0, pack_row(COEF_W'($urandom_range(0, 32767) - 16384),
                                             COEF_W'($urandom_range(0, 32767) - 16384),
                                             COEF_W'($urandom_range(0, 32767) - 16384)));
                write_reg(CFG_ROT1, ROW_W'({$urandom, $urandom}));
                write_reg(CFG_ROT2, pack_row(COEF_W'($urandom_range(0, 32767) - 16384),
                                             COEF_W'($urandom_range(0, 32767) - 16384),
                                             COEF_W'($urandom_range(0, 32767) - 16384)));
                write_reg(CFG_SHIFT_X, rand_shift());
                write_reg(CFG_SHIFT_Y, rand_shift());
                write_reg(CFG_SHIFT_Z, rand_shift());
                write_reg(CFG_MARGIN, 48'($urandom_range(0, 1000)));
                write_reg(CFG_BCOUNT, 48'd8);
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned added;
        rot_row[0]    = ROW0_RESET;
        rot_row[1]    = ROW1_RESET;
        rot_row[2]    = ROW2_RESET;
        shift_mm[0]   = 0;
        shift_mm[1]   = 0;
        shift_mm[2]   = 0;
        margin_mm     = MARGIN_RESET;
        box_count_reg = 0;
        kept_so_far   = '0;
        foreach (bound_mm[i])
            bound_mm[i] = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset settings. With no boxes active every
        // point is kept, including those at the ends of the coordinate range,
        // and the count clears after the frame end.
        send_gap_pct   = 37;
        sink_stall_pct = 52;
        add_point(COORD_TOP, COORD_BOTTOM, '0);
        add_point(COORD_BOTTOM, COORD_TOP, '1);
        add_point('0, '0, '0);
        beats_to_send[$].fe = 1'b1;
        // Box 0 is a cube of +-100 mm; box 1 is reversed on every axis, so
        // it can never drop anything.
        for (int a = 0; a < 3; a++) begin
            add_bound(BIDX_W'(2 * a), -24'sd100);
            add_bound(BIDX_W'(2 * a + 1), 24'sd100);
        end
        for (int a = 0; a < 3; a++) begin
            add_bound(BIDX_W'(BOUNDS_PER_BOX + 2 * a), 24'sd500);
            add_bound(BIDX_W'(BOUNDS_PER_BOX + 2 * a + 1), 24'sd400);
        end
        // Indexes past the last slot must leave the stored bounds untouched.
        add_bound(BIDX_W'(BOUND_SLOTS), COORD_TOP);
        add_bound(6'd63, COORD_BOTTOM);
        wait_drained();
        write_reg(CFG_BCOUNT, 48'd2);
        add_point(24'sd0, 24'sd0, 24'sd0);          // well inside box 0
        add_point(24'sd130, -24'sd130, 24'sd130);   // on the widened faces
        add_point(24'sd131, 24'sd0, 24'sd0);        // one millimetre outside
        add_point(24'sd450, 24'sd450, 24'sd450);    // inside the reversed box
        add_point(-24'sd130, 24'sd130, -24'sd131);
        beats_to_send[$].fe = 1'b1;
        wait_drained();

        // Random part, one setting after another. Each setting is sent in two
        // halves with a full drain between them.
        for (int unsigned ph = 0; ph < PHASE_COUNT; ph++) begin
            if (ph < 2) begin
                send_gap_pct   = 37;
                sink_stall_pct = 52;
            end else if (ph < 4) begin
                send_gap_pct   = 52;
                sink_stall_pct = 37;
            end else begin
                send_gap_pct   = 0;
                sink_stall_pct = 0;
            end
            setup_phase(ph);
            // Every slot gets a bound before any wide box count reads it.
            if (ph == 0) begin
                for (int unsigned i = 0; i < BOUND_SLOTS; i++)
                    add_bound(BIDX_W'(i), COORD_W'(longint'($urandom_range(0, 4000)) - 2000));
            end
            for (int half = 0; half < 2; half++) begin
                added = 0;
                while (added < PHASE_BEATS / 2)
                    add_sequence(added);
                wait_drained();
            end
        end

        $display("Checked %0d point results, %0d of them dropped, with %0d bound writes",
                 results_checked, drops_seen, bounds_sent);
        $display("over %0d register settings from plain to arbitrary rotations.",
                 PHASE_COUNT + 1);
        if (fault_count == 0) begin
            $display("** point_self_box_filter_unit: PASSED **");
        end else begin
            $display("** point_self_box_filter_unit: FAILED **");
        end
        $finish;
    end

endmodule

/* point_self_box_filter_unit.f */
rtl/psbf_pkg.sv
rtl/psbf_ram.sv
rtl/point_self_box_filter_unit.sv
test/tb.sv
